// File: src/skf_pkg.sv
// ----------------------------------------------------------------------------
// skf_pkg
// Shared constants and types for the scalar Kalman filter unit.
// ----------------------------------------------------------------------------
package skf_pkg;

    localparam int unsigned GAIN_W    = 17;
    localparam int unsigned DIV_STEPS = 17;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS + 1);
    localparam int unsigned ADDR_W    = 4;

    localparam logic [GAIN_W-1:0] ONE_Q16  = 17'h10000;
    localparam logic [50:0]       HALF_Q16 = 51'd32768;

    localparam logic [1:0] REG_MEAS_NOISE = 2'd0;
    localparam logic [1:0] REG_PROC_NOISE = 2'd1;
    localparam logic [1:0] REG_INIT_EST   = 2'd2;
    localparam logic [1:0] REG_INIT_COV   = 2'd3;

    localparam logic [31:0] RST_MEAS_NOISE = 32'd65536;
    localparam logic [31:0] RST_PROC_NOISE = 32'd655;
    localparam logic [31:0] RST_INIT_EST   = 32'd0;
    localparam logic [31:0] RST_INIT_COV   = 32'd65536;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// File: src/scalar_kalman_filter_unit.sv
// ----------------------------------------------------------------------------
// scalar_kalman_filter_unit
// One-dimensional Kalman filter over Q16.16 samples, built around a
// serial divider and one shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
//  channel   direction  valid        stall        payload
//  in        in         i_in_valid   o_in_stall   i_mode, i_measurement
//  out       out        o_out_valid  i_out_stall  o_filtered_value, o_gain
//  config    in         psel/penable pready       paddr, pwdata, prdata
//
//  A measure item runs prediction, the gain divider, two multiplies and the
//  covariance update; the gain divider takes most of that time. A restart item
//  goes straight to its result. No new item is taken before that result is out.
//  o_in_stall is high from acceptance until the result enters the output
//  register; the output register holds a result while o_out_valid waits.
//  Reset is synchronous, active low, and loads the register reset values,
//  a zero estimate and a covariance of 1.0.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_mode,
    input  logic signed [31:0]            i_measurement,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [31:0]            o_filtered_value,
    output logic [skf_pkg::GAIN_W-1:0]    o_gain,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [skf_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PRED   = 3'd1;
    localparam logic [2:0] S_DSTART = 3'd2;
    localparam logic [2:0] S_DWAIT  = 3'd3;
    localparam logic [2:0] S_MUL1   = 3'd4;
    localparam logic [2:0] S_MUL2   = 3'd5;
    localparam logic [2:0] S_COV    = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0]                     r_state;
    logic [2:0]                     n_state;
    logic [31:0]                    r_meas_noise;
    logic [31:0]                    r_proc_noise;
    logic [31:0]                    r_init_est;
    logic [31:0]                    r_init_cov;
    logic [31:0]                    r_est;
    logic [31:0]                    r_cov;
    logic [31:0]                    r_meas;
    logic [31:0]                    r_p1;
    logic [32:0]                    r_den;
    logic signed [32:0]             r_innov;
    logic [skf_pkg::GAIN_W-1:0]     r_gain;
    logic                           r_out_valid;
    logic signed [31:0]             r_out_value;
    logic [skf_pkg::GAIN_W-1:0]     r_out_gain;

    logic                           in_take;
    logic                           out_take;
    logic                           out_free;
    logic                           cfg_write;
    logic [1:0]                     reg_idx;
    logic [32:0]                    p1_sum;
    logic [31:0]                    p1_sat;
    skf_pkg::t_div_stat             div_stat;
    logic [skf_pkg::GAIN_W-1:0]     div_quot;
    logic [skf_pkg::GAIN_W-1:0]     mul_a;
    logic signed [33:0]             mul_b;
    logic signed [50:0]             mul_prod;
    logic signed [50:0]             rounded;

    assign in_take   = i_in_valid && !o_in_stall;
    assign out_take  = r_out_valid && !i_out_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = paddr[3:2];

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_filtered_value = r_out_value;
    assign o_gain           = r_out_gain;
    assign pready           = 1'b1;

    always_comb begin
        unique case (reg_idx)
            skf_pkg::REG_MEAS_NOISE: prdata = r_meas_noise;
            skf_pkg::REG_PROC_NOISE: prdata = r_proc_noise;
            skf_pkg::REG_INIT_EST:   prdata = r_init_est;
            skf_pkg::REG_INIT_COV:   prdata = r_init_cov;
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meas_noise <= skf_pkg::RST_MEAS_NOISE;
            r_proc_noise <= skf_pkg::RST_PROC_NOISE;
            r_init_est   <= skf_pkg::RST_INIT_EST;
            r_init_cov   <= skf_pkg::RST_INIT_COV;
        end else if (cfg_write) begin
            unique case (reg_idx)
                skf_pkg::REG_MEAS_NOISE: r_meas_noise <= pwdata;
                skf_pkg::REG_PROC_NOISE: r_proc_noise <= pwdata;
                skf_pkg::REG_INIT_EST:   r_init_est   <= pwdata;
                skf_pkg::REG_INIT_COV:   r_init_cov   <= pwdata;
                default: ;
            endcase
        end
    end

    assign p1_sum = {1'b0, r_cov} + {1'b0, r_proc_noise};
    assign p1_sat = p1_sum[32] ? 32'hFFFF_FFFF : p1_sum[31:0];

    skf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DSTART),
        .i_num   (r_p1),
        .i_den   (r_den),
        .o_stat  (div_stat),
        .o_quot  (div_quot)
    );

    always_comb begin
        if (r_state == S_MUL1) begin
            mul_a = r_gain;
            mul_b = {r_innov[32], r_innov};
        end else begin
            mul_a = skf_pkg::ONE_Q16 - r_gain;
            mul_b = $signed({2'b00, r_p1});
        end
    end

    skf_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

    assign rounded = mul_prod + $signed(skf_pkg::HALF_Q16);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (in_take) n_state = i_mode ? S_DONE : S_PRED;
            S_PRED:   n_state = S_DSTART;
            S_DSTART: n_state = S_DWAIT;
            S_DWAIT:  if (div_stat.done) n_state = S_MUL1;
            S_MUL1:   n_state = S_MUL2;
            S_MUL2:   n_state = S_COV;
            S_COV:    n_state = S_DONE;
            S_DONE:   if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_est       <= '0;
            r_cov       <= {15'd0, skf_pkg::ONE_Q16};
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_IDLE && in_take && i_mode) begin
                r_est <= r_init_est;
                r_cov <= r_init_cov;
            end
            if (r_state == S_MUL2) begin
                r_est <= r_est + rounded[47:16];
            end
            if (r_state == S_COV) begin
                r_cov <= rounded[47:16];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && in_take) begin
            r_meas <= i_measurement;
            r_gain <= '0;
        end
        if (r_state == S_PRED) begin
            r_p1    <= p1_sat;
            r_den   <= {1'b0, p1_sat} + {1'b0, r_meas_noise};
            r_innov <= $signed({r_meas[31], r_meas}) - $signed({r_est[31], r_est});
        end
        if (r_state == S_DWAIT && div_stat.done) begin
            r_gain <= (r_den == '0) ? '0 : div_quot;
        end
        if (r_state == S_DONE && out_free) begin
            r_out_value <= r_est;
            r_out_gain  <= r_gain;
        end
    end

    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_gain <= skf_pkg::ONE_Q16)
        else $error("gain above 1.0");

    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> r_state == S_DWAIT)
        else $error("divider finished outside its wait state");

    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> o_in_stall)
        else $error("next item taken before the current one finished");

    a_cov_not_above_p1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_COV |=> r_cov <= $past(r_p1))
        else $error("covariance grew in the update");

endmodule

// File: src/skf_div.sv
// ----------------------------------------------------------------------------
// skf_div
// Restoring divider for the gain, one quotient bit per cycle.
// Computes floor(num * 65536 / den) for num <= den.
// ----------------------------------------------------------------------------
module skf_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [31:0]                   i_num,
    input  logic [32:0]                   i_den,
    output skf_pkg::t_div_stat            o_stat,
    output logic [skf_pkg::GAIN_W-1:0]    o_quot
);

    logic [33:0]                    r_rem;
    logic [32:0]                    r_den;
    logic [skf_pkg::GAIN_W-1:0]     r_quo;
    logic [skf_pkg::CNT_W-1:0]      r_cnt;
    logic                           r_busy;
    logic                           r_done;

    logic [34:0] trial;
    logic        bit_set;
    logic [33:0] rem_keep;

    assign trial    = {1'b0, r_rem} - {2'b00, r_den};
    assign bit_set  = !trial[34];
    assign rem_keep = bit_set ? trial[33:0] : r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= skf_pkg::CNT_W'(skf_pkg::DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == skf_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {2'b00, i_num};
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= {rem_keep[32:0], 1'b0};
            r_quo <= {r_quo[skf_pkg::GAIN_W-2:0], bit_set};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quo;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a running division");

    a_start_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy && !r_done)
        else $error("divider did not start");

    a_cnt_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_busy && !$past(i_start)) |-> r_cnt == '0)
        else $error("divider count left over while idle");

endmodule

// File: src/skf_mul.sv
// ----------------------------------------------------------------------------
// skf_mul
// Shared 17 x 34 bit signed multiplier with registered product.
// ----------------------------------------------------------------------------
module skf_mul (
    input  logic                          i_clk,
    input  logic [skf_pkg::GAIN_W-1:0]    i_a,
    input  logic signed [33:0]            i_b,
    output logic signed [50:0]            o_prod
);

    logic signed [51:0] prod_full;
    logic signed [50:0] r_prod;

    assign prod_full = $signed({1'b0, i_a}) * i_b;

    always_ff @(posedge i_clk) begin
        r_prod <= prod_full[50:0];
    end

    assign o_prod = r_prod;

endmodule

// File: tb/skf_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// skf_tb_pkg
// Item codes shared by the Kalman filter testbench and its checker, and the
// result record used by the checker.
// ----------------------------------------------------------------------------
package skf_tb_pkg;

    typedef enum logic {
        MODE_MEASURE = 1'b0,
        MODE_RESTART = 1'b1
    } t_item_mode;

    typedef struct packed {
        logic signed [31:0]              value;
        logic [skf_pkg::GAIN_W-1:0]      gain;
    } t_filter_out;

endpackage

// File: tb/kalman_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kalman_result_checker
// Watches the item, result and register ports of the scalar Kalman filter
// unit. Keeps its own copy of the registers, the estimate and the covariance,
// computes the filtered value and gain of every accepted item in fixed point
// and compares each accepted result, field by field, with the oldest one.
// ----------------------------------------------------------------------------
module kalman_result_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic                          i_mode,
    input  logic signed [31:0]            i_measurement,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic signed [31:0]            i_filtered_value,
    input  logic [skf_pkg::GAIN_W-1:0]    i_gain,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic                          i_pready,
    input  logic [skf_pkg::ADDR_W-1:0]    i_paddr,
    input  logic [31:0]                   i_pwdata,
    output int                            o_pending,
    output int                            o_mismatches
);
    import skf_pkg::*;
    import skf_tb_pkg::*;

    logic [31:0]        meas_noise;
    logic [31:0]        proc_noise;
    logic signed [31:0] init_est;
    logic [31:0]        init_cov;
    logic signed [31:0] kf_estimate;
    logic [31:0]        kf_covariance;

    t_filter_out pending_estimates[$];
    t_filter_out want;
    int          pending_count = 0;
    int          mismatches    = 0;

    assign o_pending    = pending_count;
    assign o_mismatches = mismatches;

    function automatic t_filter_out advance_filter(input t_item_mode m,
                                                   input logic signed [31:0] meas);
        logic [32:0]  cov_sum;
        logic [31:0]  p_pred;
        logic [33:0]  denom;
        logic [63:0]  quo;
        logic [63:0]  cov_prod;
        logic [GAIN_W-1:0] g;
        longint       innov;
        longint       delta;
        longint       nxt;
        t_filter_out  r;
        g = '0;
        if (m == MODE_RESTART) begin
            kf_estimate   = init_est;
            kf_covariance = init_cov;
        end else begin
            cov_sum = {1'b0, kf_covariance} + {1'b0, proc_noise};
            p_pred  = cov_sum[32] ? 32'hFFFF_FFFF : cov_sum[31:0];
            denom   = {2'b00, p_pred} + {2'b00, meas_noise};
            if (denom != '0) begin
                quo = {16'h0000, p_pred, 16'h0000} / {30'd0, denom};
                g   = (quo > 64'd65536) ? ONE_Q16 : quo[GAIN_W-1:0];
            end
            innov = longint'(meas) - longint'(kf_estimate);
            delta = (longint'({47'd0, g}) * innov + 64'sd32768) >>> 16;
            nxt   = longint'(kf_estimate) + delta;
            if (nxt > 64'sd2147483647)
                nxt = 64'sd2147483647;
            if (nxt < -64'sd2147483648)
                nxt = -64'sd2147483648;
            kf_estimate   = nxt[31:0];
            cov_prod      = {32'd0, p_pred} * (64'd65536 - {47'd0, g}) + 64'd32768;
            kf_covariance = cov_prod[47:16];
        end
        r.value = kf_estimate;
        r.gain  = g;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            meas_noise    = RST_MEAS_NOISE;
            proc_noise    = RST_PROC_NOISE;
            init_est      = RST_INIT_EST;
            init_cov      = RST_INIT_COV;
            kf_estimate   = '0;
            kf_covariance = 32'd65536;
            pending_estimates.delete();
            pending_count <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[ADDR_W-1:2])
                    REG_MEAS_NOISE: meas_noise = i_pwdata;
                    REG_PROC_NOISE: proc_noise = i_pwdata;
                    REG_INIT_EST:   init_est   = i_pwdata;
                    REG_INIT_COV:   init_cov   = i_pwdata;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (pending_estimates.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual value %h gain %h",
                             $time, i_filtered_value, i_gain);
                    mismatches++;
                end else begin
                    want = pending_estimates.pop_front();
                    if (i_filtered_value !== want.value) begin
                        $display("%0t: filtered_value expected %h actual %h",
                                 $time, want.value, i_filtered_value);
                        mismatches++;
                    end
                    if (i_gain !== want.gain) begin
                        $display("%0t: gain expected %h actual %h",
                                 $time, want.gain, i_gain);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                pending_estimates.push_back(advance_filter(t_item_mode'(i_mode),
                                                           i_measurement));
            pending_count <= pending_estimates.size();
        end
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the scalar Kalman filter unit. Programs the noise
// and restart registers through the register port while the unit is idle,
// sends directed items at the extremes and then random phases of measure
// and restart items, most with random gaps and output stalls, including one long
// output hold. A checker beside the unit predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    import skf_pkg::*;
    import skf_tb_pkg::*;

    localparam int RESET_CYCLES    = 10;
    localparam int SETTLE_CYCLES   = 30;
    localparam int HOLD_CYCLES     = 600;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 140;
    localparam int CYCLE_LIMIT     = 800000;

    logic                 clk            = 1'b0;
    logic                 rst_n          = 1'b0;
    logic                 in_valid       = 1'b0;
    logic                 in_stall;
    logic                 mode           = MODE_MEASURE;
    logic signed [31:0]   measurement    = '0;
    logic                 out_valid;
    logic                 out_stall      = 1'b0;
    logic signed [31:0]   filtered_value;
    logic [GAIN_W-1:0]    gain;
    logic                 psel           = 1'b0;
    logic                 penable        = 1'b0;
    logic                 pwrite         = 1'b0;
    logic [ADDR_W-1:0]    paddr          = '0;
    logic [31:0]          pwdata         = '0;
    logic [31:0]          prdata;
    logic                 pready;

    int pending;
    int fail_count;
    int cycle_count = 0;
    bit calm         = 1'b0;
    bit hold_request = 1'b0;
    bit hold_done    = 1'b0;

    always #4 clk = ~clk;

    scalar_kalman_filter_unit DUT (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_mode           (mode),
        .i_measurement    (measurement),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_filtered_value (filtered_value),
        .o_gain           (gain),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    kalman_result_checker result_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_mode           (mode),
        .i_measurement    (measurement),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_filtered_value (filtered_value),
        .i_gain           (gain),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_pready         (pready),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .o_pending        (pending),
        .o_mismatches     (fail_count)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL scalar_kalman_filter_unit");
            $finish;
        end
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 70);
    endfunction

    function automatic logic [31:0] rand_noise();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12)
            return 32'h0000_0000;
        if (r < 24)
            return 32'hFFFF_FFFF;
        if (r < 60)
            return $urandom_range(0, 32'h0003_FFFF);
        return $urandom();
    endfunction

    function automatic logic [31:0] rand_start();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 32'h7FFF_FFFF;
        if (r < 30)
            return 32'h8000_0000;
        return $urandom();
    endfunction

    function automatic logic [31:0] rand_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            case ($urandom_range(0, 3))
                0: return 32'h7FFF_FFFF;
                1: return 32'h8000_0000;
                2: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        if (r < 40)
            return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
        return $urandom();
    endfunction

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_filter(input logic [31:0] r_noise, input logic [31:0] q_noise,
                                  input logic [31:0] start_est, input logic [31:0] start_cov);
        reg_write(REG_MEAS_NOISE, r_noise);
        reg_write(REG_PROC_NOISE, q_noise);
        reg_write(REG_INIT_EST, start_est);
        reg_write(REG_INIT_COV, start_cov);
    endtask

    task automatic send_item(input t_item_mode m, input logic [31:0] value);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= m;
        measurement <= value;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin : out_stall_gen
        int run_len;
        wait (rst_n);
        forever begin
            if (hold_request && !hold_done) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end else if (calm) begin
                out_stall <= 1'b0;
                @(posedge clk);
            end else begin
                out_stall <= ($urandom_range(0, 2) == 0);
                run_len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                       : $urandom_range(1, 4);
                repeat (run_len) @(posedge clk);
            end
        end
    end

    initial begin : stimulus
        int p;
        int k;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(MODE_MEASURE, 32'h7FFF_FFFF);
        send_item(MODE_MEASURE, 32'h8000_0000);
        send_item(MODE_MEASURE, 32'h0000_0000);
        send_item(MODE_MEASURE, 32'hFFFF_FFFF);
        send_item(MODE_RESTART, 32'h5A5A_A5A5);
        send_item(MODE_MEASURE, 32'h1234_5678);
        settle();

        // zero denominator: no noise and no covariance
        program_filter(32'h0, 32'h0, 32'h0, 32'h0);
        send_item(MODE_RESTART, 32'hFFFF_FFFF);
        send_item(MODE_MEASURE, 32'h7FFF_FFFF);
        send_item(MODE_MEASURE, 32'h8000_0000);
        settle();

        // covariance saturation, largest noise, top estimate
        program_filter(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_item(MODE_RESTART, 32'h0);
        send_item(MODE_MEASURE, 32'h8000_0000);
        send_item(MODE_MEASURE, 32'h8000_0000);
        send_item(MODE_MEASURE, 32'h7FFF_FFFF);
        settle();

        // unity gain from the bottom estimate
        program_filter(32'h0, 32'h1, 32'h8000_0000, 32'hFFFF_FFFF);
        send_item(MODE_RESTART, 32'h7FFF_FFFF);
        send_item(MODE_MEASURE, 32'h7FFF_FFFF);
        send_item(MODE_MEASURE, 32'h8000_0000);
        send_item(MODE_RESTART, 32'h8000_0000);
        settle();

        for (p = 0; p < RANDOM_PHASES; p++) begin
            program_filter(rand_noise(), rand_noise(), rand_start(), rand_noise());
            calm         = (p % 4 == 3);
            hold_request = (p == 2);
            for (k = 0; k < ITEMS_PER_PHASE; k++)
                send_item(($urandom_range(0, 99) < 8) ? MODE_RESTART : MODE_MEASURE,
                          rand_sample());
            settle();
        end

        if (fail_count == 0)
            $display("PASS scalar_kalman_filter_unit");
        else
            $display("FAIL scalar_kalman_filter_unit");
        $finish;
    end

endmodule

// File: filelist.f
src/skf_pkg.sv
src/skf_div.sv
src/skf_mul.sv
src/scalar_kalman_filter_unit.sv
tb/skf_tb_pkg.sv
tb/kalman_result_checker.sv
tb/testbench.sv
